FILE: hdl/bblur_pkg.sv
// Shared types, constants and the reciprocal table of the 3x3 box blur.
// No dependencies.
package bblur_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CFG_DATA_W     = 13;
    localparam int CFG_INDEX_W    = 2;
    localparam int WIDTH_REG_W    = 11;
    localparam int HEIGHT_REG_W   = 13;
    localparam int RECIP_SHIFT    = 20;
    localparam int RECIP_W        = 20;
    localparam int SUM_W          = 12;
    localparam int NUM_W          = 13;
    localparam int PIXEL_W        = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic       emit;
        logic       frame_end;
        logic       use_top;
        logic       use_bot;
        logic       use_left;
        logic       use_right;
        logic [3:0] count;
    } ctl_t;

    // ceil(2^19 / count): multiplying 2*sum+count by it and shifting right by 20
    // gives the rounded mean exactly for every reachable sum.
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] count);
        logic [RECIP_W-1:0] r;
        case (count)
            4'd1: r = 20'd524288;
            4'd2: r = 20'd262144;
            4'd3: r = 20'd174763;
            4'd4: r = 20'd131072;
            4'd5: r = 20'd104858;
            4'd6: r = 20'd87382;
            4'd7: r = 20'd74899;
            4'd8: r = 20'd65536;
            4'd9: r = 20'd58255;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/bblur_queue.sv
// Small first-in first-out queue between the front and back parts of the blur.
// Depends on nothing but its parameters.
module bblur_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             full,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [2**PW];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]    fill_reg;

    assign full  = (fill_reg == CW'(DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = store_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end
endmodule

FILE: hdl/bblur_front.sv
// Front part of the blur: configuration, raster counters and item classification.
// Depends on bblur_pkg; feeds one command per processed item into the queue.
module bblur_front #(
    parameter int MAX_WIDTH  = bblur_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bblur_pkg::MAX_HEIGHT_DEF,
    parameter int AW         = 10,
    parameter int CMD_W      = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bblur_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                               accept,
    input  logic                               opcode,
    input  logic [bblur_pkg::PIXEL_W-1:0]      pixel,
    output logic                               push,
    output logic [CMD_W-1:0]                   push_data
);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int EWW = $clog2(MAX_WIDTH + 1) + 1;

    typedef struct packed {
        logic [AW-1:0]                 addr;
        logic [bblur_pkg::PIXEL_W-1:0] px;
        bblur_pkg::ctl_t               ctl;
    } cmd_t;

    logic [bblur_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [bblur_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [AW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [RW-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic          done_reg, done_next;
    logic [EWW-1:0] eff_w;
    logic [RW:0]    eff_h;
    logic           active, ready, fend, last_col_in, last_row_out, last_col_out;
    cmd_t           cmd;

    always_comb begin
        if (width_reg == '0) begin
            eff_w = EWW'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            eff_w = EWW'(MAX_WIDTH);
        end else begin
            eff_w = EWW'(width_reg);
        end
        if (height_reg == '0) begin
            eff_h = (RW+1)'(1);
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            eff_h = (RW+1)'(MAX_HEIGHT);
        end else begin
            eff_h = (RW+1)'(height_reg);
        end
    end

    always_comb begin
        active       = accept && (done_reg || opcode == bblur_pkg::OP_PIXEL);
        ready        = (in_row_reg >= RW'(2)) || (in_row_reg == RW'(1) && in_col_reg != '0);
        last_col_in  = (EWW'(in_col_reg) + EWW'(1)) >= eff_w;
        last_col_out = (EWW'(out_col_reg) + EWW'(1)) >= eff_w;
        last_row_out = ((RW+1)'(out_row_reg) + (RW+1)'(1)) >= eff_h;
        fend         = ready && last_row_out && last_col_out;

        cmd.addr          = in_col_reg;
        cmd.px            = done_reg ? '0 : pixel;
        cmd.ctl.emit      = ready;
        cmd.ctl.frame_end = fend;
        cmd.ctl.use_top   = out_row_reg != '0;
        cmd.ctl.use_bot   = !last_row_out;
        cmd.ctl.use_left  = out_col_reg != '0;
        cmd.ctl.use_right = (in_col_reg != '0) && !last_col_out;
        cmd.ctl.count     = (4'(1) + 4'(cmd.ctl.use_top) + 4'(cmd.ctl.use_bot))
                          * (4'(1) + 4'(cmd.ctl.use_left) + 4'(cmd.ctl.use_right));

        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        done_next    = done_reg;
        if (active) begin
            if (ready) begin
                if (last_col_out) begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end else begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
            if (!done_reg && ((RW+1)'(in_row_reg) + (RW+1)'(1)) >= eff_h && last_col_in) begin
                done_next = 1'b1;
            end
            if (last_col_in) begin
                in_col_next = '0;
                in_row_next = in_row_reg + 1'b1;
            end else begin
                in_col_next = in_col_reg + 1'b1;
            end
            if (fend) begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
                done_next    = 1'b0;
            end
        end
    end

    assign push      = active;
    assign push_data = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= bblur_pkg::WIDTH_REG_W'(1024);
            height_reg  <= bblur_pkg::HEIGHT_REG_W'(1);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            done_reg    <= 1'b0;
        end else if (cfg_wr_en && (cfg_index == bblur_pkg::REG_IMAGE_WIDTH
                                   || cfg_index == bblur_pkg::REG_IMAGE_HEIGHT)) begin
            if (cfg_index == bblur_pkg::REG_IMAGE_WIDTH) begin
                width_reg <= cfg_wr_data[bblur_pkg::WIDTH_REG_W-1:0];
            end else begin
                height_reg <= cfg_wr_data;
            end
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            done_reg    <= 1'b0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            done_reg    <= done_next;
        end
    end
endmodule

FILE: hdl/bblur_back.sv
// Back part of the blur: line stores, window, masked sums and the rounded mean.
// Depends on bblur_pkg; takes commands from the queue and drives the result register.
module bblur_back #(
    parameter int AW    = 10,
    parameter int CMD_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  logic [CMD_W-1:0] q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_red,
    output logic [7:0]       m_out_green,
    output logic [7:0]       m_out_blue,
    output logic             m_frame_end
);
    localparam int PW   = bblur_pkg::PIXEL_W;
    localparam int PR_W = bblur_pkg::NUM_W + bblur_pkg::RECIP_W;

    typedef struct packed {
        logic [AW-1:0]   addr;
        logic [PW-1:0]   px;
        bblur_pkg::ctl_t ctl;
    } cmd_t;

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_MUL, ST_OUT} state_t;

    logic [PW-1:0] older_mem [2**AW];
    logic [PW-1:0] newer_mem [2**AW];
    logic [PW-1:0] older_rd_reg, newer_rd_reg;
    logic [PW-1:0] win_l_reg [3];
    logic [PW-1:0] win_c_reg [3];
    cmd_t          cmd_reg, head;
    state_t        state_reg;
    logic [bblur_pkg::NUM_W-1:0] num_reg [3];
    logic [PR_W-1:0]             prod_reg [3];
    logic [PW-1:0]               col_new [3];
    logic [bblur_pkg::NUM_W-1:0] num_next [3];
    logic [bblur_pkg::SUM_W-1:0] sum;
    logic [bblur_pkg::RECIP_W-1:0] recip_val;
    logic [2:0] row_use;

    assign head  = cmd_t'(q_head);
    assign q_pop = (state_reg == ST_IDLE) && !q_empty;
    assign recip_val = bblur_pkg::recip(cmd_reg.ctl.count);

    always_comb begin
        col_new[0] = older_rd_reg;
        col_new[1] = newer_rd_reg;
        col_new[2] = cmd_reg.px;
        row_use = {cmd_reg.ctl.use_bot, 1'b1, cmd_reg.ctl.use_top};
        for (int ch = 0; ch < 3; ch++) begin
            sum = '0;
            for (int r = 0; r < 3; r++) begin
                if (row_use[r]) begin
                    sum = sum + bblur_pkg::SUM_W'(win_c_reg[r][16-8*ch +: 8]);
                    if (cmd_reg.ctl.use_left) begin
                        sum = sum + bblur_pkg::SUM_W'(win_l_reg[r][16-8*ch +: 8]);
                    end
                    if (cmd_reg.ctl.use_right) begin
                        sum = sum + bblur_pkg::SUM_W'(col_new[r][16-8*ch +: 8]);
                    end
                end
            end
            num_next[ch] = {sum, 1'b0} + bblur_pkg::NUM_W'(cmd_reg.ctl.count);
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg      <= head;
            older_rd_reg <= older_mem[head.addr];
            newer_rd_reg <= newer_mem[head.addr];
        end
        if (state_reg == ST_EXEC) begin
            older_mem[cmd_reg.addr] <= newer_rd_reg;
            newer_mem[cmd_reg.addr] <= cmd_reg.px;
            for (int ch = 0; ch < 3; ch++) begin
                num_reg[ch] <= num_next[ch];
            end
        end
        if (state_reg == ST_MUL) begin
            for (int ch = 0; ch < 3; ch++) begin
                prod_reg[ch] <= PR_W'(num_reg[ch]) * PR_W'(recip_val);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            m_valid   <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                win_l_reg[r] <= '0;
                win_c_reg[r] <= '0;
            end
        end else begin
            if (m_valid && m_ready && state_reg != ST_OUT) begin
                m_valid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    for (int r = 0; r < 3; r++) begin
                        win_l_reg[r] <= win_c_reg[r];
                        win_c_reg[r] <= col_new[r];
                    end
                    state_reg <= cmd_reg.ctl.emit ? ST_MUL : ST_IDLE;
                end
                ST_MUL: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (!m_valid || m_ready) begin
                        m_valid     <= 1'b1;
                        m_out_red   <= prod_reg[0][bblur_pkg::RECIP_SHIFT +: 8];
                        m_out_green <= prod_reg[1][bblur_pkg::RECIP_SHIFT +: 8];
                        m_out_blue  <= prod_reg[2][bblur_pkg::RECIP_SHIFT +: 8];
                        m_frame_end <= cmd_reg.ctl.frame_end;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: hdl/box_blur_3x3_top.sv
// Top level of the streaming 3x3 box blur with edge-clipped rounded mean.
// Depends on bblur_pkg, bblur_front, bblur_queue and bblur_back.
//
//   Port group   Direction  Handshake            Contents
//   s_*          in         s_valid / s_ready    opcode and one RGB pixel
//   m_*          out        m_valid / m_ready    blurred RGB pixel and frame_end
//   cfg_*        in         cfg_wr_en            image_width (0), image_height (1)
//
// The front takes one item per cycle while the queue has room. The back takes no new
// item until it is through with the last; an item with a result passes line store
// read, window update with sums, reciprocal multiply and result register, one with
// none ends after the window update. Reset clears counters, window and control state.
// A full queue stalls s_ready; a held result stalls the back, then the front via the queue.
module box_blur_3x3_top #(
    parameter int MAX_WIDTH  = bblur_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bblur_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bblur_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic [7:0]                        s_in_red,
    input  logic [7:0]                        s_in_green,
    input  logic [7:0]                        s_in_blue,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [7:0]                        m_out_red,
    output logic [7:0]                        m_out_green,
    output logic [7:0]                        m_out_blue,
    output logic                              m_frame_end
);
    localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMD_W = AW + bblur_pkg::PIXEL_W + $bits(bblur_pkg::ctl_t);

    logic             push, pop, q_full, q_empty;
    logic [CMD_W-1:0] push_data, q_head;

    assign s_ready = !q_full;

    bblur_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT),
        .AW        (AW),
        .CMD_W     (CMD_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .accept     (s_valid && s_ready),
        .opcode     (s_opcode),
        .pixel      ({s_in_red, s_in_green, s_in_blue}),
        .push       (push),
        .push_data  (push_data)
    );

    bblur_queue #(
        .WIDTH(CMD_W),
        .DEPTH(bblur_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .pop      (pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    bblur_back #(
        .AW   (AW),
        .CMD_W(CMD_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_red  (m_out_red),
        .m_out_green(m_out_green),
        .m_out_blue (m_out_blue),
        .m_frame_end(m_frame_end)
    );
endmodule

FILE: hdl/bblur_checker.sv
// Port-level checks for the box blur top level, attached by the bind below.
// Depends on box_blur_3x3_top.
module bblur_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_red,
    input logic [7:0] m_out_green,
    input logic [7:0] m_out_blue,
    input logic       m_frame_end
);
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_red) && $stable(m_out_green)
                                && $stable(m_out_blue) && $stable(m_frame_end))
        else $error("Stalled result changed.");

    a_valid_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown(m_valid))
        else $error("Result valid is unknown.");
endmodule

bind box_blur_3x3_top bblur_checker u_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_red  (m_out_red),
    .m_out_green(m_out_green),
    .m_out_blue (m_out_blue),
    .m_frame_end(m_frame_end)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench for box_blur_3x3_top: random framed pixel streams with
// drain ticks, configuration changes between phases and random flow control.
// Depends on bblur_pkg and the box_blur_3x3_top RTL.
typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
} blur_pixel_t;

class BlurScoreboard;
    logic [10:0]     width_reg = 11'd1024;
    logic [12:0]     height_reg = 13'd1;
    logic [23:0]     older_row[1024];
    logic [23:0]     newer_row[1024];
    logic [23:0]     window[9];
    int unsigned     in_col, in_row, out_col, out_row;
    bit              input_done;
    blur_pixel_t     expected_pixels[$];
    int              errors;

    function new();
        foreach (window[i]) window[i] = '0;
        foreach (older_row[i]) begin
            older_row[i] = '0;
            newer_row[i] = '0;
        end
        restart_frame();
    endfunction

    function void restart_frame();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        input_done = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [12:0] value);
        if (index == bblur_pkg::REG_IMAGE_WIDTH) begin
            width_reg = value[10:0];
        end else if (index == bblur_pkg::REG_IMAGE_HEIGHT) begin
            height_reg = value;
        end else begin
            return;
        end
        restart_frame();
    endfunction

    function int unsigned cols();
        if (width_reg == 0) return 1;
        if (width_reg > 1024) return 1024;
        return width_reg;
    endfunction

    function int unsigned rows();
        if (height_reg == 0) return 1;
        if (height_reg > 4096) return 4096;
        return height_reg;
    endfunction

    function blur_pixel_t window_mean(int centre, int unsigned w, int unsigned h);
        int unsigned sum_r, sum_g, sum_b, cnt;
        int col;
        blur_pixel_t p;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        cnt = 0;
        for (int dr = 0; dr < 3; dr++) begin
            if (dr == 0 && out_row == 0) continue;
            if (dr == 2 && out_row + 1 >= h) continue;
            for (int dc = -1; dc <= 1; dc++) begin
                if (dc < 0 && out_col == 0) continue;
                if (dc > 0 && out_col + 1 >= w) continue;
                col = centre + dc;
                if (col > 2) continue;
                sum_r += window[dr * 3 + col][23:16];
                sum_g += window[dr * 3 + col][15:8];
                sum_b += window[dr * 3 + col][7:0];
                cnt++;
            end
        end
        p.red = 8'((2 * sum_r + cnt) / (2 * cnt));
        p.green = 8'((2 * sum_g + cnt) / (2 * cnt));
        p.blue = 8'((2 * sum_b + cnt) / (2 * cnt));
        p.frame_end = 0;
        return p;
    endfunction

    function void note(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int unsigned w, h, ic, ir, idx;
        logic [23:0] px, old_top;
        bit is_pixel, primed, emitted;
        blur_pixel_t p;
        w = cols();
        h = rows();
        ic = in_col;
        ir = in_row;
        px = '0;
        is_pixel = 0;
        emitted = 0;
        if (!input_done) begin
            if (op == bblur_pkg::OP_DRAIN) return;
            is_pixel = 1;
            px = {r, g, b};
        end
        idx = ic % 1024;
        old_top = older_row[idx];
        primed = (ir >= 2) || (ir == 1 && ic >= 1);
        if (primed && ic == 0) begin
            p = window_mean(2, w, h);
            emitted = 1;
        end
        older_row[idx] = newer_row[idx];
        window[0] = window[1];
        window[1] = window[2];
        window[3] = window[4];
        window[4] = window[5];
        window[6] = window[7];
        window[7] = window[8];
        window[5] = older_row[idx];
        window[8] = px;
        newer_row[idx] = px;
        window[2] = old_top;
        if (primed && ic != 0) begin
            p = window_mean(1, w, h);
            emitted = 1;
        end
        if (emitted) begin
            p.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
            expected_pixels.push_back(p);
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        if (is_pixel && ir + 1 >= h && ic + 1 >= w) input_done = 1;
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (emitted && p.frame_end) restart_frame();
    endfunction

    function void check(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
        blur_pixel_t e;
        if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected item rgb=%h %h %h frame_end=%b", $time, r, g, b, fe);
            errors++;
            return;
        end
        e = expected_pixels.pop_front();
        if (r !== e.red) begin
            $display("%0t: out_red expected %h actual %h", $time, e.red, r);
            errors++;
        end
        if (g !== e.green) begin
            $display("%0t: out_green expected %h actual %h", $time, e.green, g);
            errors++;
        end
        if (b !== e.blue) begin
            $display("%0t: out_blue expected %h actual %h", $time, e.blue, b);
            errors++;
        end
        if (fe !== e.frame_end) begin
            $display("%0t: frame_end expected %b actual %b", $time, e.frame_end, fe);
            errors++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 64;
    localparam int ITEM_TARGET = 1150;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = 1'b0;
    logic [7:0]  s_in_red = '0;
    logic [7:0]  s_in_green = '0;
    logic [7:0]  s_in_blue = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_red, m_out_green, m_out_blue;
    logic        m_frame_end;

    BlurScoreboard blur_sb = new();
    int            cycle_count = 0;
    int            items_sent = 0;
    int            burst_left = 0;
    int            stall_mode = 0;

    box_blur_3x3_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_in_red(s_in_red), .s_in_green(s_in_green), .s_in_blue(s_in_blue),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_red(m_out_red), .m_out_green(m_out_green), .m_out_blue(m_out_blue),
        .m_frame_end(m_frame_end)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (aresetn && s_valid && s_ready)
            blur_sb.note(s_opcode, s_in_red, s_in_green, s_in_blue);
        if (aresetn && m_valid && m_ready)
            blur_sb.check(m_out_red, m_out_green, m_out_blue, m_frame_end);
        if (cycle_count % 256 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ($urandom_range(0, 3) == 0);
            default: m_ready <= (cycle_count % 8 < 5);
        endcase
    end

    function automatic logic [7:0] channel_value();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_item(logic op);
        if (burst_left == 0) begin
            if ($urandom_range(0, 2) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_opcode <= op;
        s_in_red <= channel_value();
        s_in_green <= channel_value();
        s_in_blue <= channel_value();
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (blur_sb.expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [12:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wr_data <= value;
        @(posedge aclk);
        blur_sb.write_reg(index, value);
        cfg_wr_en <= 1'b0;
    endtask

    // Frames with drain ticks, cut short at cap items, plus some stray drains and ignored pixels.
    task automatic run_phase(logic [12:0] w_val, logic [12:0] h_val, int frames, int cap);
        int unsigned w, h;
        int sent;
        wait_idle();
        write_reg(bblur_pkg::REG_IMAGE_WIDTH, w_val);
        write_reg(bblur_pkg::REG_IMAGE_HEIGHT, h_val);
        w = blur_sb.cols();
        h = blur_sb.rows();
        sent = 0;
        for (int f = 0; f < frames && sent < cap; f++) begin
            for (int i = 0; i < w * h && sent < cap; i++) begin
                if ($urandom_range(0, 29) == 0) begin
                    send_item(bblur_pkg::OP_DRAIN);
                    sent++;
                end
                send_item(bblur_pkg::OP_PIXEL);
                sent++;
            end
            for (int i = 0; i <= w && sent < cap; i++) begin
                send_item(($urandom_range(0, 4) == 0) ? bblur_pkg::OP_PIXEL
                                                       : bblur_pkg::OP_DRAIN);
                sent++;
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_phase(13'd3, 13'd3, 1, 20);
        run_phase(13'd1, 13'd1, 3, 10);
        run_phase(13'd0, 13'd0, 2, 10);
        run_phase(13'd1, 13'd5, 1, 20);
        run_phase(13'd5, 13'd1, 1, 20);
        run_phase(13'd2047, 13'd8191, 1, 1100);
        run_phase(13'd1024, 13'd4096, 1, 40);
        run_phase(13'd4, 13'd3, 2, 100);
        while (items_sent < ITEM_TARGET)
            run_phase(13'($urandom_range(1, 12)), 13'($urandom_range(1, 9)),
                      $urandom_range(1, 3), 200);
        wait_idle();
        if (blur_sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
